// ===== rtl/level_stream_tree_linker_core_assert.svh =====
// Assertion macros for the tree linker core.
// LTL_ASSERT_NOW  : same-cycle implication under clock and reset.
// LTL_ASSERT_NEXT : next-cycle implication under clock and reset.
`ifndef LEVEL_STREAM_TREE_LINKER_CORE_ASSERT_SVH
`define LEVEL_STREAM_TREE_LINKER_CORE_ASSERT_SVH

`ifndef SYNTH

`define LTL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define LTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LTL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)

`define LTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/ltl_pkg.sv =====
package ltl_pkg;

    // Sizing
    localparam int MAX_DEPTH  = 128;
    localparam int INDEX_BITS = 20;
    localparam int LEVEL_BITS = 7;
    localparam int LINE_BITS  = 24;
    localparam int ADDR_BITS  = $clog2(MAX_DEPTH);

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [LINE_BITS-1:0]  t_line;
    typedef logic [ADDR_BITS-1:0]  t_addr;

    // Result role codes
    typedef enum logic [2:0] {
        ROLE_ROOT    = 3'd0,
        ROLE_FIRST   = 3'd1,
        ROLE_SIBLING = 3'd2,
        ROLE_SKIPPED = 3'd3,
        ROLE_END     = 3'd4
    } t_role;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FIRST_LVL = 2'd1,
        ERR_JUMP      = 2'd2
    } t_err;

endpackage

// ===== rtl/ltl_in_if.sv =====
interface ltl_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    ltl_pkg::t_level    level;
    ltl_pkg::t_line     line_number;

    modport source (output valid, op, level, line_number, input ready);
    modport sink   (input valid, op, level, line_number, output ready);
endinterface

// ===== rtl/ltl_out_if.sv =====
interface ltl_out_if;
    logic               valid;
    logic               ready;
    ltl_pkg::t_index    item_index;
    logic [2:0]         role;
    ltl_pkg::t_index    parent_index;
    ltl_pkg::t_index    sibling_index;
    logic               record_done;
    ltl_pkg::t_index    record_root;
    logic [1:0]         error_code;
    ltl_pkg::t_line     error_line;

    modport source (output valid, item_index, role, parent_index, sibling_index,
                    record_done, record_root, error_code, error_line,
                    input ready);
    modport sink   (input valid, item_index, role, parent_index, sibling_index,
                    record_done, record_root, error_code, error_line,
                    output ready);
endinterface

// ===== rtl/ltl_ram.sv =====
// One write port, two read ports, registered read data (old data on collision).
module ltl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== rtl/level_stream_tree_linker_core.sv =====
// Channel  | Dir | Payload                                        | Handshake
// ---------+-----+------------------------------------------------+-------------
// i_in     | in  | op, level, line_number                         | valid/ready
// o_out    | out | item_index, role, parent_index, sibling_index, | valid/ready
//          |     | record_done, record_root, error_code, error_line|
//
// One item per cycle sustained while the output is not stalled.
// Stage 1 holds the item and the two level-stack reads, stage 2 is the result register.
// The level stack is a 1W2R RAM; the write of the previous item is forwarded.
// Synchronous active-low reset clears control state; the stack needs no clearing.
// A stalled output backs up into stage 1 and then drops i_in.ready.
`include "level_stream_tree_linker_core_assert.svh"

module level_stream_tree_linker_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ltl_in_if.sink    i_in,
    ltl_out_if.source o_out
);

    typedef enum logic [1:0] {
        MODE_INITIAL = 2'd0,
        MODE_MAIN    = 2'd1,
        MODE_ERROR   = 2'd2
    } t_mode;

    typedef struct packed {
        logic            op;
        ltl_pkg::t_level level;
        ltl_pkg::t_line  line_number;
    } t_item;

    typedef struct packed {
        ltl_pkg::t_index item_index;
        ltl_pkg::t_role  role;
        ltl_pkg::t_index parent_index;
        ltl_pkg::t_index sibling_index;
        logic            record_done;
        ltl_pkg::t_index record_root;
        ltl_pkg::t_err   error_code;
        ltl_pkg::t_line  error_line;
    } t_result;

    // Pipeline and linker state
    logic            r_s1_valid;
    t_item           r_s1;
    logic            r_out_valid;
    t_result         r_out;
    t_mode           r_mode;
    ltl_pkg::t_level r_prev_level;
    ltl_pkg::t_index r_root;
    ltl_pkg::t_index r_next_index;
    logic            r_fwd_valid;
    ltl_pkg::t_addr  r_fwd_addr;
    ltl_pkg::t_index r_fwd_data;

    t_result         n_out;
    t_mode           n_mode;
    ltl_pkg::t_level n_prev_level;
    ltl_pkg::t_index n_root;
    ltl_pkg::t_index n_next_index;

    logic            in_fire;
    logic            s1_adv;
    logic            wr_en;
    ltl_pkg::t_addr  wr_addr;
    ltl_pkg::t_index wr_data;
    ltl_pkg::t_addr  in_addr_par;
    ltl_pkg::t_addr  in_addr_cur;
    ltl_pkg::t_addr  s1_addr_par;
    ltl_pkg::t_addr  s1_addr_cur;
    ltl_pkg::t_index ram_par;
    ltl_pkg::t_index ram_cur;
    ltl_pkg::t_index par_data;
    ltl_pkg::t_index cur_data;
    logic            lvl_ok;
    logic            prev_ok;

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    // Level stack addresses: parent level and own level
    assign in_addr_par = ltl_pkg::ADDR_BITS'(ltl_pkg::t_level'(i_in.level - 1'b1));
    assign in_addr_cur = ltl_pkg::ADDR_BITS'(i_in.level);
    assign s1_addr_par = ltl_pkg::ADDR_BITS'(ltl_pkg::t_level'(r_s1.level - 1'b1));
    assign s1_addr_cur = ltl_pkg::ADDR_BITS'(r_s1.level);

    ltl_ram #(
        .WIDTH (ltl_pkg::INDEX_BITS),
        .DEPTH (ltl_pkg::MAX_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (s1_adv && wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_re      (in_fire),
        .i_raddr_a (in_addr_par),
        .i_raddr_b (in_addr_cur),
        .o_rdata_a (ram_par),
        .o_rdata_b (ram_cur)
    );

    // Forward the write that landed on the same edge as this item's read
    assign par_data = (r_fwd_valid && r_fwd_addr == s1_addr_par) ? r_fwd_data : ram_par;
    assign cur_data = (r_fwd_valid && r_fwd_addr == s1_addr_cur) ? r_fwd_data : ram_cur;

    assign lvl_ok  = 32'(r_s1.level) < ltl_pkg::MAX_DEPTH;
    assign prev_ok = 32'(r_prev_level) < ltl_pkg::MAX_DEPTH;

    // Linking decision for the item in stage 1
    always_comb begin
        n_mode       = r_mode;
        n_prev_level = r_prev_level;
        n_root       = r_root;
        n_next_index = r_next_index;
        wr_en        = 1'b0;
        wr_addr      = s1_addr_cur;
        wr_data      = r_next_index;

        n_out               = '0;
        n_out.role          = ltl_pkg::ROLE_ROOT;
        n_out.error_code    = ltl_pkg::ERR_NONE;
        n_out.error_line    = r_s1.line_number;

        if (r_s1.op) begin
            // End of list: close the open record and return to reset state
            n_out.role = ltl_pkg::ROLE_END;
            if (r_mode == MODE_MAIN) begin
                n_out.record_done = 1'b1;
                n_out.record_root = r_root;
            end
            n_mode       = MODE_INITIAL;
            n_prev_level = '0;
            n_root       = '0;
            n_next_index = '0;
        end else begin
            n_out.item_index = r_next_index;
            n_next_index     = ltl_pkg::t_index'(r_next_index + 1'b1);
            case (r_mode)
                MODE_MAIN: begin
                    if (r_s1.level == '0) begin
                        n_out.role        = ltl_pkg::ROLE_ROOT;
                        n_out.record_done = 1'b1;
                        n_out.record_root = r_root;
                        n_root            = r_next_index;
                        n_prev_level      = '0;
                        wr_en             = 1'b1;
                    end else if (r_s1.level <= r_prev_level && prev_ok) begin
                        n_out.role          = ltl_pkg::ROLE_SIBLING;
                        n_out.parent_index  = par_data;
                        n_out.sibling_index = cur_data;
                        n_prev_level        = r_s1.level;
                        wr_en               = 1'b1;
                    end else if ({1'b0, r_s1.level} == {1'b0, r_prev_level} + 1'b1
                                 && lvl_ok) begin
                        n_out.role         = ltl_pkg::ROLE_FIRST;
                        n_out.parent_index = par_data;
                        n_prev_level       = r_s1.level;
                        wr_en              = 1'b1;
                    end else begin
                        // Illegal jump: report the open record, skip, enter error mode
                        n_out.role        = ltl_pkg::ROLE_SKIPPED;
                        n_out.error_code  = ltl_pkg::ERR_JUMP;
                        n_out.record_done = 1'b1;
                        n_out.record_root = r_root;
                        n_mode            = MODE_ERROR;
                    end
                end
                default: begin
                    // Initial or error mode: wait for a level-0 line
                    if (r_s1.level == '0) begin
                        n_out.role   = ltl_pkg::ROLE_ROOT;
                        n_root       = r_next_index;
                        n_prev_level = '0;
                        n_mode       = MODE_MAIN;
                        wr_en        = 1'b1;
                    end else begin
                        n_out.role = ltl_pkg::ROLE_SKIPPED;
                        if (r_mode == MODE_INITIAL) begin
                            n_out.error_code = ltl_pkg::ERR_FIRST_LVL;
                            n_mode           = MODE_ERROR;
                        end
                    end
                end
            endcase
        end
    end

    // State, pipeline and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_INITIAL;
            r_prev_level <= '0;
            r_root       <= '0;
            r_next_index <= '0;
            r_fwd_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                r_s1        <= '{op: i_in.op, level: i_in.level,
                                 line_number: i_in.line_number};
                r_fwd_valid <= s1_adv && wr_en;
                r_fwd_addr  <= wr_addr;
                r_fwd_data  <= wr_data;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_out        <= n_out;
                r_mode       <= n_mode;
                r_prev_level <= n_prev_level;
                r_root       <= n_root;
                r_next_index <= n_next_index;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output channel
    assign o_out.valid         = r_out_valid;
    assign o_out.item_index    = r_out.item_index;
    assign o_out.role          = r_out.role;
    assign o_out.parent_index  = r_out.parent_index;
    assign o_out.sibling_index = r_out.sibling_index;
    assign o_out.record_done   = r_out.record_done;
    assign o_out.record_root   = r_out.record_root;
    assign o_out.error_code    = r_out.error_code;
    assign o_out.error_line    = r_out.error_line;

    // Checks
    `LTL_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, s1_adv && r_s1.op, r_mode == MODE_INITIAL && r_next_index == '0 && r_root == '0, "end of list did not reset state")
    `LTL_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, s1_adv && !r_s1.op, r_next_index == ltl_pkg::t_index'($past(r_next_index) + 1'b1), "line index did not advance")
    `LTL_ASSERT_NEXT(a_root_taken, i_clk, i_rst_n, s1_adv && !r_s1.op && n_out.role == ltl_pkg::ROLE_ROOT, r_root == $past(r_next_index) && r_mode == MODE_MAIN, "new root not recorded")
    `LTL_ASSERT_NOW(a_err_skips, i_clk, i_rst_n, r_out_valid && r_out.error_code != ltl_pkg::ERR_NONE, r_out.role == ltl_pkg::ROLE_SKIPPED, "error on a linked line")
    `LTL_ASSERT_NOW(a_main_depth, i_clk, i_rst_n, r_mode == MODE_MAIN, prev_ok, "stack level out of range in main mode")

endmodule

// ===== test/level_stream_tree_linker_core_tb.sv =====
`timescale 1ns / 1ps

module level_stream_tree_linker_core_tb;

    localparam logic OP_LINE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        SCAN_START   = 2'd0,
        SCAN_LINKING = 2'd1,
        SCAN_RESYNC  = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic            op;
        ltl_pkg::t_level level;
        ltl_pkg::t_line  line_number;
    } t_line_item;

    typedef struct packed {
        ltl_pkg::t_index item_index;
        ltl_pkg::t_role  role;
        ltl_pkg::t_index parent_index;
        ltl_pkg::t_index sibling_index;
        logic            record_done;
        ltl_pkg::t_index record_root;
        ltl_pkg::t_err   error_code;
        ltl_pkg::t_line  error_line;
    } t_link_result;

    typedef struct {
        t_line_item   item;
        bit           typed;
        t_link_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ltl_in_if  in_ch ();
    ltl_out_if out_ch ();

    level_stream_tree_linker_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Linker state as the block should hold it
    t_scan_mode      lnk_mode;
    ltl_pkg::t_level lnk_prev;
    ltl_pkg::t_index lnk_stack [ltl_pkg::MAX_DEPTH];
    ltl_pkg::t_index lnk_root;
    ltl_pkg::t_index lnk_next;

    t_link_result pending_links [$];
    t_dir_row     dir_tab [$];

    bit src_idle;
    bit snk_idle;
    bit climb_pending;
    int n_fail;
    int n_results;
    int n_records;
    int n_skipped;
    int n_flagged;
    int deepest_link;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // Expected result of one accepted transfer; advances the linker state
    function automatic t_link_result link_line(t_line_item it);
        t_link_result r;
        ltl_pkg::t_index idx;
        r = '0;
        r.role = ltl_pkg::ROLE_ROOT;
        r.error_code = ltl_pkg::ERR_NONE;
        r.error_line = it.line_number;
        if (it.op == OP_END) begin
            r.role = ltl_pkg::ROLE_END;
            if (lnk_mode == SCAN_LINKING) begin
                r.record_done = 1'b1;
                r.record_root = lnk_root;
            end
            lnk_mode = SCAN_START;
            lnk_prev = '0;
            lnk_root = '0;
            lnk_next = '0;
        end else begin
            idx = lnk_next;
            lnk_next = lnk_next + 1'b1;
            r.item_index = idx;
            if (lnk_mode != SCAN_LINKING) begin
                if (it.level == '0) begin
                    r.role = ltl_pkg::ROLE_ROOT;
                    lnk_root = idx;
                    lnk_stack[0] = idx;
                    lnk_prev = '0;
                    lnk_mode = SCAN_LINKING;
                end else begin
                    r.role = ltl_pkg::ROLE_SKIPPED;
                    if (lnk_mode == SCAN_START) begin
                        r.error_code = ltl_pkg::ERR_FIRST_LVL;
                        lnk_mode = SCAN_RESYNC;
                    end
                end
            end else if (it.level == '0) begin
                // new record closes the open one
                r.role = ltl_pkg::ROLE_ROOT;
                r.record_done = 1'b1;
                r.record_root = lnk_root;
                lnk_root = idx;
                lnk_stack[0] = idx;
                lnk_prev = '0;
            end else if (it.level <= lnk_prev) begin
                r.role = ltl_pkg::ROLE_SIBLING;
                r.parent_index = lnk_stack[it.level - 1'b1];
                r.sibling_index = lnk_stack[it.level];
                lnk_stack[it.level] = idx;
                lnk_prev = it.level;
            end else if (int'(it.level) == int'(lnk_prev) + 1
                         && int'(it.level) < ltl_pkg::MAX_DEPTH) begin
                r.role = ltl_pkg::ROLE_FIRST;
                r.parent_index = lnk_stack[lnk_prev];
                lnk_stack[it.level] = idx;
                lnk_prev = it.level;
                if (int'(it.level) > deepest_link) deepest_link = int'(it.level);
            end else begin
                // level jump: close the record and resync on the next level 0
                r.role = ltl_pkg::ROLE_SKIPPED;
                r.error_code = ltl_pkg::ERR_JUMP;
                r.record_done = 1'b1;
                r.record_root = lnk_root;
                lnk_mode = SCAN_RESYNC;
            end
        end
        return r;
    endfunction

    function automatic t_dir_row dir_row(logic op, int level, int line, bit typed, int idx,
                                         ltl_pkg::t_role role, int parent, int sib, bit done,
                                         int root, ltl_pkg::t_err err);
        t_dir_row row;
        row.item.op = op;
        row.item.level = ltl_pkg::t_level'(level);
        row.item.line_number = ltl_pkg::t_line'(line);
        row.typed = typed;
        row.want.item_index = ltl_pkg::t_index'(idx);
        row.want.role = role;
        row.want.parent_index = ltl_pkg::t_index'(parent);
        row.want.sibling_index = ltl_pkg::t_index'(sib);
        row.want.record_done = done;
        row.want.record_root = ltl_pkg::t_index'(root);
        row.want.error_code = err;
        row.want.error_line = ltl_pkg::t_line'(line);
        return row;
    endfunction

    // Directed lines; typed rows carry the result by hand, the rest use the predictor
    function automatic void load_dir_tab();
        // bad first line, then resync skipping without error
        dir_tab.push_back(dir_row(OP_LINE,   5, 'h000000, 1, 0,
            ltl_pkg::ROLE_SKIPPED, 0, 0, 0, 0, ltl_pkg::ERR_FIRST_LVL));
        dir_tab.push_back(dir_row(OP_LINE,   3, 'hFFFFFF, 1, 1,
            ltl_pkg::ROLE_SKIPPED, 0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   0, 'h000002, 1, 2,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h000003, 1, 3,
            ltl_pkg::ROLE_FIRST,   2, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   2, 'h000004, 1, 4,
            ltl_pkg::ROLE_FIRST,   3, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   2, 'h000005, 1, 5,
            ltl_pkg::ROLE_SIBLING, 3, 4, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h000006, 1, 6,
            ltl_pkg::ROLE_SIBLING, 2, 3, 0, 0, ltl_pkg::ERR_NONE));
        // level jump closes record 2, then skip until level 0
        dir_tab.push_back(dir_row(OP_LINE,   3, 'h000007, 1, 7,
            ltl_pkg::ROLE_SKIPPED, 0, 0, 1, 2, ltl_pkg::ERR_JUMP));
        dir_tab.push_back(dir_row(OP_LINE, 127, 'h555555, 1, 8,
            ltl_pkg::ROLE_SKIPPED, 0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   0, 'hAAAAAA, 1, 9,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h00000A, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   0, 'h00000B, 1, 11,
            ltl_pkg::ROLE_ROOT,    0, 0, 1, 9, ltl_pkg::ERR_NONE));
        // end of list while linking, then while idle
        dir_tab.push_back(dir_row(OP_END,  127, 'hFFFFFF, 1, 0,
            ltl_pkg::ROLE_END,     0, 0, 1, 11, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_END,    0, 'h000000, 1, 0,
            ltl_pkg::ROLE_END,     0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   0, 'h00000E, 1, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_END,    0, 'h00000F, 1, 0,
            ltl_pkg::ROLE_END,     0, 0, 1, 0, ltl_pkg::ERR_NONE));
        // end of list while resyncing reports nothing
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h000010, 1, 0,
            ltl_pkg::ROLE_SKIPPED, 0, 0, 0, 0, ltl_pkg::ERR_FIRST_LVL));
        dir_tab.push_back(dir_row(OP_END,   42, 'h000011, 1, 0,
            ltl_pkg::ROLE_END,     0, 0, 0, 0, ltl_pkg::ERR_NONE));
        // back up two levels in one step
        dir_tab.push_back(dir_row(OP_LINE,   0, 'h800000, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h7FFFFF, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   2, 'h000014, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   3, 'h000015, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   1, 'h000016, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   2, 'h000017, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
        dir_tab.push_back(dir_row(OP_LINE,   0, 'h000018, 0, 0,
            ltl_pkg::ROLE_ROOT,    0, 0, 0, 0, ltl_pkg::ERR_NONE));
    endfunction

    // Mostly well-formed records, with deep climbs, noise levels and list ends
    function automatic t_line_item random_line_item(bit allow_end);
        t_line_item it;
        int r;
        int pick;
        it.op = OP_LINE;
        it.level = '0;
        it.line_number = ltl_pkg::t_line'($urandom);
        r = $urandom_range(0, 999);
        if (climb_pending) begin
            if (lnk_mode == SCAN_LINKING) it.level = lnk_prev + 1'b1;
            if (int'(it.level) == ltl_pkg::MAX_DEPTH - 1) climb_pending = 1'b0;
        end else if (allow_end && r < 25) begin
            it.op = OP_END;
            it.level = ltl_pkg::t_level'($urandom);
        end else if (r < 90) begin
            it.level = ltl_pkg::t_level'($urandom_range(0, ltl_pkg::MAX_DEPTH - 1));
        end else if (r < 93) begin
            climb_pending = 1'b1;
        end else if (lnk_mode == SCAN_LINKING) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                it.level = '0;
            end else if (pick < 6 && int'(lnk_prev) < ltl_pkg::MAX_DEPTH - 1) begin
                it.level = lnk_prev + 1'b1;
            end else if (lnk_prev != '0) begin
                it.level = ltl_pkg::t_level'($urandom_range(1, int'(lnk_prev)));
            end
        end
        return it;
    endfunction

    function automatic int pick_gap(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one item, wait for its transfer, then queue what it should produce
    task automatic push_item(input t_line_item it, input bit typed, input t_link_result want);
        int gap;
        t_link_result exp;
        gap = pick_gap(src_idle);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.level <= it.level;
        in_ch.line_number <= it.line_number;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        exp = link_line(it);
        pending_links.push_back(typed ? want : exp);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] exp, input logic [31:0] got);
        if (exp !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, got);
            n_fail++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_link_result exp;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (out_ch.record_done === 1'b1) n_records++;
            if (out_ch.role === ltl_pkg::ROLE_SKIPPED) n_skipped++;
            if (out_ch.error_code !== ltl_pkg::ERR_NONE) n_flagged++;
            if (pending_links.size() == 0) begin
                $error("result transfer with nothing expected");
                n_fail++;
            end else begin
                exp = pending_links.pop_front();
                cmp_field("item_index", 32'(exp.item_index), 32'(out_ch.item_index));
                cmp_field("role", 32'(exp.role), 32'(out_ch.role));
                cmp_field("parent_index", 32'(exp.parent_index), 32'(out_ch.parent_index));
                cmp_field("sibling_index", 32'(exp.sibling_index), 32'(out_ch.sibling_index));
                cmp_field("record_done", 32'(exp.record_done), 32'(out_ch.record_done));
                cmp_field("record_root", 32'(exp.record_root), 32'(out_ch.record_root));
                cmp_field("error_code", 32'(exp.error_code), 32'(out_ch.error_code));
                cmp_field("error_line", 32'(exp.error_line), 32'(out_ch.error_line));
            end
        end
    end

    // Result-side backpressure
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap(snk_idle);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin
        t_link_result blank;
        blank = '0;
        n_fail = 0;
        n_results = 0;
        n_records = 0;
        n_skipped = 0;
        n_flagged = 0;
        deepest_link = 0;
        climb_pending = 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        lnk_mode = SCAN_START;
        lnk_prev = '0;
        lnk_root = '0;
        lnk_next = '0;
        foreach (lnk_stack[i]) lnk_stack[i] = '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_LINE;
        in_ch.level <= '0;
        in_ch.line_number <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_dir_tab();
        foreach (dir_tab[i]) push_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

        // random part, idling switched in stretches of 100 transfers
        for (int k = 0; k < 800; k++) begin
            src_idle = ((k / 100) % 3) != 1;
            snk_idle = ((k / 100) % 4) != 2;
            if (k == 200) climb_pending = 1'b1;
            if (k == 400) begin
                // hold off until the block has drained
                in_ch.valid <= 1'b0;
                while (pending_links.size() != 0) @(posedge i_clk);
            end
            push_item(random_line_item(1'b1), 1'b0, blank);
        end

        in_ch.valid <= 1'b0;
        while (pending_links.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Linked %0d transfers: %0d records closed, %0d lines skipped, %0d errors flagged",
                 n_results, n_records, n_skipped, n_flagged);
        $display("Deepest child level %0d, with stalls and gaps on both channels", deepest_link);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ltl_pkg.sv
rtl/ltl_in_if.sv
rtl/ltl_out_if.sv
rtl/ltl_ram.sv
rtl/level_stream_tree_linker_core.sv
test/level_stream_tree_linker_core_tb.sv
